>>> hdl/hsvc_pkg.sv
package hsvc_pkg;

    // Field widths
    localparam int HUE_W  = 16;
    localparam int SAT_W  = 9;
    localparam int VAL_W  = 9;
    localparam int CHAN_W = 8;

    // Hue geometry in 1/16 degree units
    localparam int TURN     = 5760;
    localparam int SECTOR   = 960;
    localparam int HMOD_W   = 13;   // hue mod TURN < 8192
    localparam int SEC_W    = 3;    // sector 0..5
    localparam int DIFF_W   = 10;   // 0..960

    // Datapath widths
    localparam int VS_W   = SAT_W + VAL_W;   // v*s
    localparam int PROD_W = VS_W + DIFF_W;   // v*s*d
    localparam int VB_W   = 27;              // v*256*960
    localparam int NUM_W  = PROD_W + 1;      // signed channel numerator

    // v*256*960 and full scale 65536*960 = 15 * 2^22
    localparam int VBASE_MUL   = 245760;
    localparam int DEN         = 62914560;
    localparam int SCALE_MUL   = 17;         // 255/15
    localparam int SCALE_SHIFT = 22;
    localparam int SCALE_W     = 31;

    typedef logic [SEC_W-1:0] sector_t;

    // Which term a channel carries before the offset is added
    typedef enum logic [1:0] {
        ROLE_CHROMA,
        ROLE_SECOND,
        ROLE_ZERO
    } role_t;

    typedef struct packed {
        role_t red;
        role_t green;
        role_t blue;
    } roles_t;

    typedef struct packed {
        sector_t             sector;
        logic [DIFF_W-1:0]   diff;    // 960 - k, the weight subtracted for the secondary term
    } split_t;

    function automatic roles_t sector_roles(sector_t sector);
        roles_t r;
        case (sector)
            3'd0:    r = '{ROLE_CHROMA, ROLE_SECOND, ROLE_ZERO};
            3'd1:    r = '{ROLE_SECOND, ROLE_CHROMA, ROLE_ZERO};
            3'd2:    r = '{ROLE_ZERO,   ROLE_CHROMA, ROLE_SECOND};
            3'd3:    r = '{ROLE_ZERO,   ROLE_SECOND, ROLE_CHROMA};
            3'd4:    r = '{ROLE_SECOND, ROLE_ZERO,   ROLE_CHROMA};
            default: r = '{ROLE_CHROMA, ROLE_ZERO,   ROLE_SECOND};
        endcase
        return r;
    endfunction

endpackage

>>> hdl/hsvc_in_if.sv
interface hsvc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [hsvc_pkg::HUE_W-1:0] hue;
    logic        [hsvc_pkg::SAT_W-1:0] saturation;
    logic        [hsvc_pkg::VAL_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

>>> hdl/hsvc_out_if.sv
interface hsvc_out_if;
    logic                        valid;
    logic                        ready;
    logic [hsvc_pkg::CHAN_W-1:0] red;
    logic [hsvc_pkg::CHAN_W-1:0] green;
    logic [hsvc_pkg::CHAN_W-1:0] blue;
    logic                        hue_error;

    modport source (output valid, output red, output green, output blue,
                    output hue_error, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input hue_error, output ready);
endinterface

>>> hdl/hsv_to_rgb_converter.sv
// Channel | Dir  | Payload                                   | Transfer
// hsv     | in   | hue s16, saturation u9, brightness u9     | valid & ready
// rgb     | out  | red u8, green u8, blue u8, hue_error u1   | valid & ready
//
// Five register stages; a result passes each stage register in turn and shows
// on rgb from the last one, where it waits for its output transfer.
// One pixel per clock sustained while rgb.ready stays high; every stage holds a valid bit.
// Stalls: a stage takes new data when it is empty or the stage after it moves,
// so bubbles collapse and hsv.ready follows rgb.ready through that chain.
// rst_n (async, active low) clears the valid bits only.
module hsv_to_rgb_converter (
    input  logic               clk,
    input  logic               rst_n,
    hsvc_in_if.sink            hsv,
    hsvc_out_if.source         rgb
);

    localparam int NS = 5;

    // Per-stage valid bits and advance enables
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] adv;

    always_comb
    begin
        adv[NS] = !vld_reg[NS] || rgb.ready;
        for (int i = NS - 1; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        vld_next[1] = adv[1] ? hsv.valid : vld_reg[1];
        for (int i = 2; i <= NS; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hsv.ready = adv[1];

    // ---------------- Stage 1: hue mod 360 degrees, chroma v*s ----------------
    logic                             err1_reg,  err1_next;
    logic [hsvc_pkg::HMOD_W-1:0]      hmod1_reg, hmod1_next;
    logic [hsvc_pkg::VS_W-1:0]        vs1_reg,   vs1_next;
    logic [hsvc_pkg::VAL_W-1:0]       v1_reg;

    logic [2:0]                       turns;
    logic [hsvc_pkg::HUE_W-2:0]       hue_mag;
    logic [hsvc_pkg::HUE_W-2:0]       turn_base;

    always_comb
    begin
        hue_mag = hsv.hue[hsvc_pkg::HUE_W-2:0];
        turns   = '0;
        for (int i = 1; i < 6; i++)
        begin
            if (hue_mag >= (hsvc_pkg::HUE_W-1)'(i * hsvc_pkg::TURN))
            begin
                turns = turns + 1'b1;
            end
        end
        turn_base  = (hsvc_pkg::HUE_W-1)'((hsvc_pkg::HUE_W-1)'(turns)
                     * (hsvc_pkg::HUE_W-1)'(hsvc_pkg::TURN));
        hmod1_next = hsvc_pkg::HMOD_W'(hue_mag - turn_base);
        err1_next  = hsv.hue[hsvc_pkg::HUE_W-1];
        vs1_next   = hsvc_pkg::VS_W'(hsv.brightness) * hsvc_pkg::VS_W'(hsv.saturation);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            err1_reg  <= err1_next;
            hmod1_reg <= hmod1_next;
            vs1_reg   <= vs1_next;
            v1_reg    <= hsv.brightness;
        end
    end

    // ---------------- Stage 2: sector and secondary weight ----------------
    hsvc_pkg::split_t                 split2_next;
    hsvc_pkg::split_t                 split2_reg;
    logic                             err2_reg;
    logic [hsvc_pkg::VS_W-1:0]        vs2_reg;
    logic [hsvc_pkg::VAL_W-1:0]       v2_reg;

    hsvc_sector_split u_split (
        .hue_mod (hmod1_reg),
        .split   (split2_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            split2_reg <= split2_next;
            err2_reg   <= err1_reg;
            vs2_reg    <= vs1_reg;
            v2_reg     <= v1_reg;
        end
    end

    // ---------------- Stage 3: products ----------------
    // Each channel numerator is v*256*960 - v*s*d, d one of 0, 960, weight.
    logic [hsvc_pkg::PROD_W-1:0]      px3_reg, px3_next;
    logic [hsvc_pkg::PROD_W-1:0]      pc3_reg, pc3_next;
    logic [hsvc_pkg::VB_W-1:0]        vb3_reg, vb3_next;
    hsvc_pkg::sector_t                sec3_reg;
    logic                             err3_reg;

    always_comb
    begin
        px3_next = hsvc_pkg::PROD_W'(vs2_reg) * hsvc_pkg::PROD_W'(split2_reg.diff);
        pc3_next = hsvc_pkg::PROD_W'(vs2_reg) * hsvc_pkg::PROD_W'(hsvc_pkg::SECTOR);
        vb3_next = hsvc_pkg::VB_W'(v2_reg) * hsvc_pkg::VB_W'(hsvc_pkg::VBASE_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            px3_reg  <= px3_next;
            pc3_reg  <= pc3_next;
            vb3_reg  <= vb3_next;
            sec3_reg <= split2_reg.sector;
            err3_reg <= err2_reg;
        end
    end

    // ---------------- Stage 4: channel numerators ----------------
    logic [hsvc_pkg::NUM_W-1:0]       nr4_reg, nr4_next;
    logic [hsvc_pkg::NUM_W-1:0]       ng4_reg, ng4_next;
    logic [hsvc_pkg::NUM_W-1:0]       nb4_reg, nb4_next;
    logic                             err4_reg;
    hsvc_pkg::roles_t                 roles3;

    function automatic logic [hsvc_pkg::NUM_W-1:0] chan_num(
        hsvc_pkg::role_t               role,
        logic [hsvc_pkg::VB_W-1:0]     vb,
        logic [hsvc_pkg::PROD_W-1:0]   pc,
        logic [hsvc_pkg::PROD_W-1:0]   px
    );
        logic [hsvc_pkg::PROD_W-1:0] sub;
        case (role)
            hsvc_pkg::ROLE_CHROMA: sub = '0;
            hsvc_pkg::ROLE_SECOND: sub = px;
            default:               sub = pc;
        endcase
        // both terms stay below 2^28, so the top bit is the sign
        return hsvc_pkg::NUM_W'(vb) - hsvc_pkg::NUM_W'(sub);
    endfunction

    always_comb
    begin
        roles3   = hsvc_pkg::sector_roles(sec3_reg);
        nr4_next = chan_num(roles3.red,   vb3_reg, pc3_reg, px3_reg);
        ng4_next = chan_num(roles3.green, vb3_reg, pc3_reg, px3_reg);
        nb4_next = chan_num(roles3.blue,  vb3_reg, pc3_reg, px3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            nr4_reg  <= nr4_next;
            ng4_reg  <= ng4_next;
            nb4_reg  <= nb4_next;
            err4_reg <= err3_reg;
        end
    end

    // ---------------- Stage 5: clip and scale to 8 bits ----------------
    // floor(255 * n / (65536*960)) = (n * 17) >> 22
    logic [hsvc_pkg::CHAN_W-1:0]      red_reg,   red_next;
    logic [hsvc_pkg::CHAN_W-1:0]      green_reg, green_next;
    logic [hsvc_pkg::CHAN_W-1:0]      blue_reg,  blue_next;
    logic                             herr_reg;

    function automatic logic [hsvc_pkg::CHAN_W-1:0] chan_scale(
        logic [hsvc_pkg::NUM_W-1:0] num,
        logic                       err
    );
        logic [hsvc_pkg::NUM_W-2:0]   clip;
        logic [hsvc_pkg::SCALE_W-1:0] prod;
        if (num[hsvc_pkg::NUM_W-1] || err)
        begin
            clip = '0;
        end
        else if (num[hsvc_pkg::NUM_W-2:0] > (hsvc_pkg::NUM_W-1)'(hsvc_pkg::DEN))
        begin
            clip = (hsvc_pkg::NUM_W-1)'(hsvc_pkg::DEN);
        end
        else
        begin
            clip = num[hsvc_pkg::NUM_W-2:0];
        end
        prod = hsvc_pkg::SCALE_W'(clip) * hsvc_pkg::SCALE_W'(hsvc_pkg::SCALE_MUL);
        return prod[hsvc_pkg::SCALE_SHIFT +: hsvc_pkg::CHAN_W];
    endfunction

    always_comb
    begin
        red_next   = chan_scale(nr4_reg, err4_reg);
        green_next = chan_scale(ng4_reg, err4_reg);
        blue_next  = chan_scale(nb4_reg, err4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            herr_reg  <= err4_reg;
        end
    end

    assign rgb.valid     = vld_reg[NS];
    assign rgb.red       = red_reg;
    assign rgb.green     = green_reg;
    assign rgb.blue      = blue_reg;
    assign rgb.hue_error = herr_reg;

endmodule

>>> hdl/hsvc_sector_split.sv
// Splits a reduced hue into its 60-degree sector and the secondary-term weight.
module hsvc_sector_split (
    input  logic [hsvc_pkg::HMOD_W-1:0] hue_mod,
    output hsvc_pkg::split_t            split
);

    hsvc_pkg::sector_t               cnt;
    logic [hsvc_pkg::HMOD_W-1:0]     base;
    logic [hsvc_pkg::DIFF_W-1:0]     pos;

    // Thermometer count of sector boundaries at or below the hue
    always_comb
    begin
        cnt = '0;
        for (int i = 1; i < 6; i++)
        begin
            if (hue_mod >= hsvc_pkg::HMOD_W'(i * hsvc_pkg::SECTOR))
            begin
                cnt = cnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        base = hsvc_pkg::HMOD_W'(hsvc_pkg::HMOD_W'(cnt) * hsvc_pkg::HMOD_W'(hsvc_pkg::SECTOR));
        pos  = hsvc_pkg::DIFF_W'(hue_mod - base);
        split.sector = cnt;
        // odd sector: k = 960 - f, weight f; even: k = f, weight 960 - f
        split.diff   = cnt[0] ? pos : hsvc_pkg::DIFF_W'(hsvc_pkg::SECTOR) - pos;
    end

endmodule

>>> hdl/hsvc_checker.sv
module hsvc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [hsvc_pkg::CHAN_W-1:0] red,
    input logic [hsvc_pkg::CHAN_W-1:0] green,
    input logic [hsvc_pkg::CHAN_W-1:0] blue,
    input logic                        hue_error
);

    // nothing comes out while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // an open output lets the whole pipe move, so the input must be open too
    a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is ready");

    a_error_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hue_error |-> (red == '0) && (green == '0) && (blue == '0))
        else $error("hue error with nonzero color");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
        && $stable(blue) && $stable(hue_error))
        else $error("stalled result changed");

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (hsv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue),
    .hue_error (rgb.hue_error)
);
